>>> rtl/hcim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID collection item matcher package
// Shared item and result types, stack control types, item and register codes.
// ----------------------------------------------------------------------------
package hcim_pkg;

  localparam int USAGE_W = 32;

  localparam logic [2:0] COLL_TYPE_PHYSICAL    = 3'd0;
  localparam logic [2:0] COLL_TYPE_APPLICATION = 3'd1;
  localparam logic [2:0] COLL_TYPE_LOGICAL     = 3'd2;

  localparam logic [2:0] KIND_COLLECTION     = 3'd3;
  localparam logic [2:0] KIND_END_COLLECTION = 3'd4;

  localparam logic [4:0] KIND_MASK_ANY       = 5'h1F;

  localparam int CARE_USAGE       = 0;
  localparam int CARE_APPLICATION = 1;
  localparam int CARE_PHYSICAL    = 2;
  localparam int CARE_LOGICAL     = 3;

  typedef enum logic [2:0] {
    CFG_WANT_USAGE       = 3'd0,
    CFG_WANT_APPLICATION = 3'd1,
    CFG_WANT_PHYSICAL    = 3'd2,
    CFG_WANT_LOGICAL     = 3'd3,
    CFG_CARE_BITS        = 3'd4,
    CFG_KIND_MASK        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               first_item;
    logic [2:0]         item_kind;
    logic [2:0]         collection_type;
    logic [USAGE_W-1:0] usage_code;
  } in_data_t;

  typedef struct packed {
    logic hit;
    logic already_found;
  } out_data_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stk_ctl_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [USAGE_W-1:0] top;
  } stk_sts_t;

endpackage

>>> rtl/hid_collection_item_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID collection item matcher
// Tracks open physical, application and logical collections of a HID report
// descriptor and flags the first item that matches the configured usages.
//
// Usage:
//   Items enter on the in_ channel (valid/ready) and each transfer yields one
//   result on the out_ channel; each result is registered. One item per cycle
//   is sustained while the receiver takes results: each stack top sits in a
//   register and the memory read of the entry below it is issued at the same
//   edge that changes the stack, so a pop is ready for the next item. Set
//   first_item on the first item of each descriptor scan.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   item is in flight; writes take effect at once.
//   Reset empties the stacks, clears the found flag and loads the register
//   defaults; no clearing pass is needed. A two-entry result buffer keeps
//   in_ready high for one more item after the receiver stalls; after that
//   in_ready drops until a result is taken.
// ----------------------------------------------------------------------------
module hid_collection_item_matcher #(
  parameter int NEST_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcim_pkg::in_data_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcim_pkg::out_data_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  logic [hcim_pkg::USAGE_W-1:0] want_usage_r;
  logic [hcim_pkg::USAGE_W-1:0] want_application_r;
  logic [hcim_pkg::USAGE_W-1:0] want_physical_r;
  logic [hcim_pkg::USAGE_W-1:0] want_logical_r;
  logic [3:0]                   care_bits_r;
  logic [4:0]                   kind_mask_r;
  logic                         done_r;
  logic                         done_nxt;

  logic                accept;
  logic                done_eff;
  logic                is_coll;
  logic                is_end;
  logic                sel_phy;
  logic                sel_app;
  logic                sel_log;
  logic                push_phy;
  logic                push_app;
  logic                push_log;
  logic                ok_phy;
  logic                ok_app;
  logic                ok_log;
  logic                ok_usage;
  logic                ok_kind;
  logic [4:0]          kind_sel;
  logic                match;
  logic                hit;
  hcim_pkg::stk_ctl_t  ctl_phy;
  hcim_pkg::stk_ctl_t  ctl_app;
  hcim_pkg::stk_ctl_t  ctl_log;
  hcim_pkg::stk_sts_t  sts_phy;
  hcim_pkg::stk_sts_t  sts_app;
  hcim_pkg::stk_sts_t  sts_log;
  hcim_pkg::out_data_t res;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      want_usage_r       <= '0;
      want_application_r <= '0;
      want_physical_r    <= '0;
      want_logical_r     <= '0;
      care_bits_r        <= '0;
      kind_mask_r        <= hcim_pkg::KIND_MASK_ANY;
    end else if (cfg_we) begin
      case (hcim_pkg::cfg_reg_t'(cfg_index))
        hcim_pkg::CFG_WANT_USAGE:       want_usage_r       <= cfg_wdata;
        hcim_pkg::CFG_WANT_APPLICATION: want_application_r <= cfg_wdata;
        hcim_pkg::CFG_WANT_PHYSICAL:    want_physical_r    <= cfg_wdata;
        hcim_pkg::CFG_WANT_LOGICAL:     want_logical_r     <= cfg_wdata;
        hcim_pkg::CFG_CARE_BITS:        care_bits_r        <= cfg_wdata[3:0];
        hcim_pkg::CFG_KIND_MASK:        kind_mask_r        <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    done_eff = done_r && !in_data.first_item;
    is_coll  = (in_data.item_kind == hcim_pkg::KIND_COLLECTION);
    is_end   = (in_data.item_kind == hcim_pkg::KIND_END_COLLECTION);
    sel_phy  = (in_data.collection_type == hcim_pkg::COLL_TYPE_PHYSICAL);
    sel_app  = (in_data.collection_type == hcim_pkg::COLL_TYPE_APPLICATION);
    sel_log  = (in_data.collection_type == hcim_pkg::COLL_TYPE_LOGICAL);

    // A first item sees empty stacks, so it is never blocked by a full one.
    push_phy = !done_eff && is_coll && sel_phy && (in_data.first_item || !sts_phy.full);
    push_app = !done_eff && is_coll && sel_app && (in_data.first_item || !sts_app.full);
    push_log = !done_eff && is_coll && sel_log && (in_data.first_item || !sts_log.full);

    ok_phy = push_phy ? (in_data.usage_code == want_physical_r)
                      : (!in_data.first_item && !sts_phy.empty &&
                         sts_phy.top == want_physical_r);
    ok_app = push_app ? (in_data.usage_code == want_application_r)
                      : (!in_data.first_item && !sts_app.empty &&
                         sts_app.top == want_application_r);
    ok_log = push_log ? (in_data.usage_code == want_logical_r)
                      : (!in_data.first_item && !sts_log.empty &&
                         sts_log.top == want_logical_r);
    ok_usage = (in_data.usage_code == want_usage_r);

    kind_sel = kind_mask_r >> in_data.item_kind;
    ok_kind  = (kind_mask_r == hcim_pkg::KIND_MASK_ANY) ||
               ((in_data.item_kind <= hcim_pkg::KIND_END_COLLECTION) && kind_sel[0]);

    match = (!care_bits_r[hcim_pkg::CARE_USAGE]       || ok_usage) &&
            (!care_bits_r[hcim_pkg::CARE_APPLICATION] || ok_app) &&
            (!care_bits_r[hcim_pkg::CARE_PHYSICAL]    || ok_phy) &&
            (!care_bits_r[hcim_pkg::CARE_LOGICAL]     || ok_log) &&
            ok_kind;
    hit = !done_eff && match;

    ctl_phy.clear = accept && in_data.first_item;
    ctl_phy.push  = accept && push_phy;
    ctl_phy.pop   = accept && !done_eff && !match && is_end && sel_phy &&
                    !in_data.first_item && !sts_phy.empty;
    ctl_app.clear = accept && in_data.first_item;
    ctl_app.push  = accept && push_app;
    ctl_app.pop   = accept && !done_eff && !match && is_end && sel_app &&
                    !in_data.first_item && !sts_app.empty;
    ctl_log.clear = accept && in_data.first_item;
    ctl_log.push  = accept && push_log;
    ctl_log.pop   = accept && !done_eff && !match && is_end && sel_log &&
                    !in_data.first_item && !sts_log.empty;

    res.hit           = hit;
    res.already_found = done_eff;

    done_nxt = accept ? (done_eff || hit) : done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
  end

  hcim_stack #(.DEPTH(NEST_DEPTH)) u_stk_phy (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_phy),
    .push_data (in_data.usage_code),
    .sts       (sts_phy)
  );

  hcim_stack #(.DEPTH(NEST_DEPTH)) u_stk_app (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_app),
    .push_data (in_data.usage_code),
    .sts       (sts_app)
  );

  hcim_stack #(.DEPTH(NEST_DEPTH)) u_stk_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_log),
    .push_data (in_data.usage_code),
    .sts       (sts_log)
  );

  hcim_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (accept),
    .push_data  (res),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_hit_sets_done : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hit) |=> done_r)
    else $error("found flag not set after a hit");

  a_done_blocks_stacks : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done_eff) |-> !(ctl_phy.push || ctl_phy.pop || ctl_app.push ||
                               ctl_app.pop || ctl_log.push || ctl_log.pop))
    else $error("stack changed after the scan was done");

  a_done_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && !(accept && in_data.first_item)) |=> done_r)
    else $error("found flag cleared without a new scan");

endmodule

>>> rtl/hcim_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collection usage stack
// Bounded stack in a synchronous memory, with the top entry held in a register
// and the entry below it kept in the registered read data of the memory.
// ----------------------------------------------------------------------------
module hcim_stack #(
  parameter int DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hcim_pkg::stk_ctl_t  ctl,
  input  logic [hcim_pkg::USAGE_W-1:0] push_data,
  output hcim_pkg::stk_sts_t  sts
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                cnt_nxt;
  logic [CW-1:0]                cnt_base;
  logic [hcim_pkg::USAGE_W-1:0] top_r;
  logic [hcim_pkg::USAGE_W-1:0] top_nxt;
  logic [hcim_pkg::USAGE_W-1:0] rd_data_r;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic [hcim_pkg::USAGE_W-1:0] mem [DEPTH];

  // The read port always follows the entry just below the next top. A push
  // writes the next top entry; the ports meet only when it fills an empty stack.
  always_comb begin
    cnt_base = ctl.clear ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    top_nxt  = top_r;
    if (ctl.push) begin
      cnt_nxt = cnt_base + CW'(1);
      top_nxt = push_data;
    end else if (ctl.pop) begin
      cnt_nxt = cnt_base - CW'(1);
      top_nxt = rd_data_r;
    end
    wr_addr = cnt_base[AW-1:0];
    rd_addr = (cnt_nxt >= CW'(2)) ? AW'(cnt_nxt - CW'(2)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= push_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == CW'(DEPTH));
  assign sts.top   = top_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("stack count exceeds depth");

  a_push_pop_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> (ctl.clear || !sts.full))
    else $error("push onto a full stack");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (!ctl.clear && !sts.empty))
    else $error("pop from an empty stack");

endmodule

>>> rtl/hcim_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry output register with skid stage between the matcher and the
// result channel.
// ----------------------------------------------------------------------------
module hcim_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  hcim_pkg::out_data_t push_data,
  output logic                can_accept,
  output logic                out_valid,
  input  logic                out_ready,
  output hcim_pkg::out_data_t out_data
);

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                skid_valid_r;
  logic                skid_valid_nxt;
  hcim_pkg::out_data_t out_data_r;
  hcim_pkg::out_data_t out_data_nxt;
  hcim_pkg::out_data_t skid_data_r;
  hcim_pkg::out_data_t skid_data_nxt;
  logic                take;

  assign take = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push_valid) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_accept = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !skid_valid_r)
    else $error("result pushed into a full buffer");

  a_skid_moves_up : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && take) |=> (out_valid_r && out_data_r == $past(skid_data_r)))
    else $error("skid entry lost on transfer");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID collection item matcher testbench
// Sends descriptor item sequences through the in_ channel under several
// register settings, predicts the hit and already_found flags of each item
// from its own copy of the collection stacks, and checks every result in
// order. Both channel sides insert random gaps, and the receiver holds off
// long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int NEST_DEPTH  = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 220;
  localparam logic [2:0] KIND_INPUT   = 3'd0;
  localparam logic [2:0] KIND_FEATURE = 3'd2;
  localparam logic [2:0] KIND_LAST    = 3'd7;
  localparam logic [2:0] TYPE_LAST    = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  hcim_pkg::in_data_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  hcim_pkg::out_data_t out_data;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  hid_collection_item_matcher #(.NEST_DEPTH(NEST_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow registers and collection stacks of the matcher.
  logic [31:0] want_usage_q = '0;
  logic [31:0] want_app_q = '0;
  logic [31:0] want_phys_q = '0;
  logic [31:0] want_log_q = '0;
  logic [3:0]  care_q = '0;
  logic [4:0]  kind_mask_q = hcim_pkg::KIND_MASK_ANY;
  logic [31:0] nest_entry [3][NEST_DEPTH];
  int          nest_top [3] = '{-1, -1, -1};
  logic        scan_done = 1'b0;

  hcim_pkg::in_data_t  pending_items [$];
  hcim_pkg::out_data_t expected_flags [$];
  int          items_queued = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          src_wait = 0;
  int          sink_wait = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;

  function automatic bit top_is(int s, logic [31:0] want);
    if (nest_top[s] < 0) return 1'b0;
    return nest_entry[s][nest_top[s]] == want;
  endfunction

  function automatic hcim_pkg::out_data_t match_item(hcim_pkg::in_data_t it);
    hcim_pkg::out_data_t r;
    bit        ok;
    int        t;
    r = '0;
    ok = 1'b1;
    t = int'(it.collection_type);
    if (it.first_item) begin
      for (int s = 0; s < 3; s++) nest_top[s] = -1;
      scan_done = 1'b0;
    end
    if (scan_done) begin
      r.already_found = 1'b1;
      return r;
    end
    if (it.item_kind == hcim_pkg::KIND_COLLECTION && t <= hcim_pkg::COLL_TYPE_LOGICAL
        && nest_top[t] < NEST_DEPTH - 1) begin
      nest_top[t]++;
      nest_entry[t][nest_top[t]] = it.usage_code;
    end
    if (care_q[hcim_pkg::CARE_USAGE] && it.usage_code != want_usage_q) ok = 1'b0;
    if (care_q[hcim_pkg::CARE_APPLICATION]
        && !top_is(hcim_pkg::COLL_TYPE_APPLICATION, want_app_q)) ok = 1'b0;
    if (care_q[hcim_pkg::CARE_PHYSICAL]
        && !top_is(hcim_pkg::COLL_TYPE_PHYSICAL, want_phys_q)) ok = 1'b0;
    if (care_q[hcim_pkg::CARE_LOGICAL]
        && !top_is(hcim_pkg::COLL_TYPE_LOGICAL, want_log_q)) ok = 1'b0;
    if (kind_mask_q != hcim_pkg::KIND_MASK_ANY
        && (it.item_kind > hcim_pkg::KIND_END_COLLECTION || !kind_mask_q[it.item_kind]))
      ok = 1'b0;
    if (ok) begin
      scan_done = 1'b1;
      r.hit = 1'b1;
      return r;
    end
    if (it.item_kind == hcim_pkg::KIND_END_COLLECTION && t <= hcim_pkg::COLL_TYPE_LOGICAL
        && nest_top[t] >= 0)
      nest_top[t]--;
    return r;
  endfunction

  function automatic void queue_item(logic first, logic [2:0] kind, logic [2:0] ctype,
                                     logic [31:0] usage);
    hcim_pkg::in_data_t it;
    it.first_item = first;
    it.item_kind = kind;
    it.collection_type = ctype;
    it.usage_code = usage;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic logic [31:0] usage_for(logic [2:0] ctype);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      case (ctype)
        hcim_pkg::COLL_TYPE_PHYSICAL:    return want_phys_q;
        hcim_pkg::COLL_TYPE_APPLICATION: return want_app_q;
        hcim_pkg::COLL_TYPE_LOGICAL:     return want_log_q;
        default:                         return want_usage_q;
      endcase
    end
    if (roll < 7) return want_usage_q;
    return $urandom();
  endfunction

  function automatic logic [31:0] random_want();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic void random_item(logic first);
    int         roll;
    logic [2:0] ctype;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0)
      ctype = 3'($urandom_range(hcim_pkg::COLL_TYPE_LOGICAL + 1, TYPE_LAST));
    else
      ctype = 3'($urandom_range(hcim_pkg::COLL_TYPE_PHYSICAL, hcim_pkg::COLL_TYPE_LOGICAL));
    if (roll < 35) begin
      queue_item(first, hcim_pkg::KIND_COLLECTION, ctype, usage_for(ctype));
    end else if (roll < 60) begin
      queue_item(first, hcim_pkg::KIND_END_COLLECTION, ctype, usage_for(ctype));
    end else if (roll < 92) begin
      queue_item(first, 3'($urandom_range(KIND_INPUT, KIND_FEATURE)), ctype, usage_for(TYPE_LAST));
    end else begin
      queue_item(first, 3'($urandom_range(hcim_pkg::KIND_END_COLLECTION + 1, KIND_LAST)),
                 3'($urandom_range(0, TYPE_LAST)), $urandom());
    end
  endfunction

  // A scan other than a noise one opens with first_item set; some scans nest
  // one collection type past the stack depth, and a few are pure noise.
  function automatic void random_scan(int len);
    logic [2:0] ctype;
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < len; i++)
        queue_item($urandom_range(0, 15) == 0, 3'($urandom()), 3'($urandom()), $urandom());
      return;
    end
    random_item(1'b1);
    if ($urandom_range(0, 5) == 0) begin
      ctype = 3'($urandom_range(hcim_pkg::COLL_TYPE_PHYSICAL, hcim_pkg::COLL_TYPE_LOGICAL));
      for (int i = $urandom_range(8, 13); i > 0; i--)
        queue_item(1'b0, hcim_pkg::KIND_COLLECTION, ctype, usage_for(ctype));
    end
    for (int i = 1; i < len; i++) random_item($urandom_range(0, 49) == 0);
  endfunction

  task automatic write_reg(hcim_pkg::cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      hcim_pkg::CFG_WANT_USAGE:       want_usage_q = value;
      hcim_pkg::CFG_WANT_APPLICATION: want_app_q = value;
      hcim_pkg::CFG_WANT_PHYSICAL:    want_phys_q = value;
      hcim_pkg::CFG_WANT_LOGICAL:     want_log_q = value;
      hcim_pkg::CFG_CARE_BITS:        care_q = value[3:0];
      hcim_pkg::CFG_KIND_MASK:        kind_mask_q = value[4:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] usage_w, logic [31:0] app_w, logic [31:0] phys_w,
                               logic [31:0] log_w, logic [3:0] care, logic [4:0] kmask);
    write_reg(hcim_pkg::CFG_WANT_USAGE, usage_w);
    write_reg(hcim_pkg::CFG_WANT_APPLICATION, app_w);
    write_reg(hcim_pkg::CFG_WANT_PHYSICAL, phys_w);
    write_reg(hcim_pkg::CFG_WANT_LOGICAL, log_w);
    write_reg(hcim_pkg::CFG_CARE_BITS, 32'(care));
    write_reg(hcim_pkg::CFG_KIND_MASK, 32'(kmask));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_flags.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Driver: presents queued items, with a random gap after each one while gaps are on.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_flags.push_back(match_item(in_data));
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (src_wait > 0) begin
          in_valid <= 1'b0;
          src_wait--;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          src_wait = gaps_on ? $urandom_range(0, 19) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and stalls the receiver at random.
  always @(posedge clk) begin
    hcim_pkg::out_data_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_flags.size() == 0) begin
          $error("unexpected result transfer: hit %0b already_found %0b",
                 out_data.hit, out_data.already_found);
          error_count++;
        end else begin
          due = expected_flags.pop_front();
          if (out_data.hit !== due.hit) begin
            $error("hit: expected %0b, actual %0b", due.hit, out_data.hit);
            error_count++;
          end
          if (out_data.already_found !== due.already_found) begin
            $error("already_found: expected %0b, actual %0b",
                   due.already_found, out_data.already_found);
            error_count++;
          end
        end
        if (results_seen == 300 || results_seen == 1200) sink_wait = 250;
        else sink_wait = stall_on ? $urandom_range(0, 19) : 0;
      end
      if (sink_wait > 0) begin
        out_ready <= 1'b0;
        sink_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings match every item: a matching end collection, then done.
    queue_item(1'b1, hcim_pkg::KIND_END_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL, '0);
    queue_item(1'b0, KIND_LAST, TYPE_LAST, '1);
    wait_drained();

    load_settings('1, '1, '0, 32'h1234_5678, 4'b1110, hcim_pkg::KIND_MASK_ANY);
    queue_item(1'b1, KIND_INPUT, hcim_pkg::COLL_TYPE_PHYSICAL, '0);
    queue_item(1'b0, hcim_pkg::KIND_END_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL, '0);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_APPLICATION, '1);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL, '0);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, TYPE_LAST - 3'd2, 32'h1234_5678);
    queue_item(1'b0, KIND_LAST, hcim_pkg::COLL_TYPE_LOGICAL, 32'h1234_5678);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_LOGICAL, 32'h1234_5678);
    queue_item(1'b0, KIND_FEATURE, hcim_pkg::COLL_TYPE_LOGICAL, '0);
    // Fill the physical stack; the last push must be dropped.
    for (int i = 0; i < NEST_DEPTH - 1; i++)
      queue_item(i == 0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL,
                 32'h0000_0005);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL, '0);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_PHYSICAL, 32'h0000_0005);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_LOGICAL, 32'h1234_5678);
    queue_item(1'b0, hcim_pkg::KIND_COLLECTION, hcim_pkg::COLL_TYPE_APPLICATION, '1);
    queue_item(1'b0, KIND_FEATURE, hcim_pkg::COLL_TYPE_APPLICATION, '1);

    for (int p = 0; p < 8; p++) begin
      int base;
      wait_drained();
      case (p)
        0: load_settings('1, '1, '1, '1, 4'hF, hcim_pkg::KIND_MASK_ANY);
        1: load_settings('0, '0, '0, '0, 4'h0, 5'h00);
        2: load_settings('0, '0, '0, '0, 4'hF, 5'(1 << hcim_pkg::KIND_END_COLLECTION));
        default:
          load_settings(random_want(), random_want(), random_want(), random_want(),
                        4'($urandom_range(0, 15)),
                        $urandom_range(0, 3) == 0 ? hcim_pkg::KIND_MASK_ANY
                                                  : 5'($urandom_range(0, 31)));
      endcase
      gaps_on = (p % 3 != 1);
      stall_on = (p % 3 != 2);
      base = items_queued;
      while (items_queued < base + PHASE_ITEMS) random_scan($urandom_range(2, 40));
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

>>> filelist.f
rtl/hcim_pkg.sv
rtl/hcim_stack.sv
rtl/hcim_obuf.sv
rtl/hid_collection_item_matcher.sv
dv/tb.sv
